// ----- sv/s2x_pkg.sv -----
package s2x_pkg;

    localparam int PIX_W          = 32;
    localparam int CFG_W          = 13;
    localparam int COORD_W        = 12;
    localparam int CFG_IDX_W      = 1;
    localparam int TDATA_W        = 4 * PIX_W + 2 * COORD_W;
    localparam int COORD_CAP      = 4096;
    localparam int RESET_WIDTH    = 320;
    localparam int RESET_HEIGHT   = 240;
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_PIXEL_BITS = 32;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // input item kinds carried on tuser
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef struct packed {
        logic               rd_en;
        logic [COORD_W-1:0] rd_col;
        logic               prev_we;
        logic [COORD_W-1:0] prev_col;
        logic               old_we;
        logic [COORD_W-1:0] old_col;
    } line_req_t;

    typedef struct packed {
        logic               emit;
        logic               drain;
        logic               use_b;
        logic               first_col;
        logic               last_col;
        logic               done;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } stage_t;

    typedef struct packed {
        logic [PIX_W-1:0] tl;
        logic [PIX_W-1:0] tr;
        logic [PIX_W-1:0] bl;
        logic [PIX_W-1:0] br;
    } blk_t;

    typedef struct packed {
        blk_t               blk;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               done;
    } result_t;

    function automatic blk_t s2x_blend(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] d,
                                       input logic [PIX_W-1:0] e, input logic [PIX_W-1:0] f,
                                       input logic [PIX_W-1:0] h);
        blk_t r;
        r.tl = e;
        r.tr = e;
        r.bl = e;
        r.br = e;
        if (b != h && d != f) begin
            r.tl = (d == b) ? d : e;
            r.tr = (f == b) ? f : e;
            r.bl = (d == h) ? d : e;
            r.br = (f == h) ? f : e;
        end
        return r;
    endfunction

endpackage

// ----- sv/scale2x_pixel_art_upscaler.sv -----
// Scale2x 2x upscaler. Send a frame's pixels in raster order on the s_ channel (tuser = 0),
// then one drain transaction (tuser = 1) per column to flush the last row; each pixel of row r
// returns the 2x2 block of row r-1 at the same column, and each drain returns one last-row
// block, with tlast on the final block of the frame. The first row returns nothing. One
// transaction is accepted every clock while s_tready is high: each item reads both line
// stores together (centre and right-hand pixel of the row above, pixel two rows up); a pixel
// writes each store once. An accepted transaction is registered into stage 1 and blended; its
// block goes into the output FIFO, which drives m_tvalid. A four-entry output FIFO absorbs
// short m_tready stalls; s_tready drops while the FIFO holds three blocks, or two with one
// more in flight. The line stores need no clearing pass after reset. Write frame_width or
// frame_height only while no transaction is in flight; a write restarts the frame at row 0.
module scale2x_pixel_art_upscaler #(
    parameter int MAX_WIDTH  = s2x_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = s2x_pkg::DEF_PIXEL_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [s2x_pkg::PIX_W-1:0]       s_tdata,   // pixel
    input  logic [0:0]                      s_tuser,   // mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // top_left, top_right, bottom_left, bottom_right, src_row, src_col
    output logic [s2x_pkg::TDATA_W-1:0]     m_tdata,
    output logic                            m_tlast,   // frame_done
    input  logic                            cfg_wr_en,
    input  logic [s2x_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [s2x_pkg::CFG_W-1:0]       cfg_wdata
);
    import s2x_pkg::*;

    localparam int DEPTH = (MAX_WIDTH < COORD_CAP) ? MAX_WIDTH : COORD_CAP;
    localparam logic [CFG_W-1:0] DEPTH_V   = CFG_W'(DEPTH);
    localparam logic [CFG_W-1:0] CAP_V     = CFG_W'(COORD_CAP);
    localparam logic [CFG_W-1:0] WIDTH_RST = (RESET_WIDTH > DEPTH) ? DEPTH_V
                                                                   : CFG_W'(RESET_WIDTH);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(RESET_HEIGHT);
    localparam logic [FIFO_AW+1:0] FILL_LIMIT = (FIFO_AW+2)'(FIFO_DEPTH - 1);

    logic [CFG_W-1:0]   w_reg, w_next;
    logic [CFG_W-1:0]   h_reg, h_next;
    logic [COORD_W-1:0] in_row_reg, in_row_next;
    logic [COORD_W-1:0] in_col_reg, in_col_next;
    logic [COORD_W-1:0] drain_col_reg, drain_col_next;
    logic               awaiting_reg, awaiting_next;

    logic                  s1_valid_reg;
    stage_t                s1_reg, s1_next;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic                  fwd_reg, fwd_next;
    logic [PIXEL_BITS-1:0] fwd_data_reg;
    logic [PIXEL_BITS-1:0] last_e_reg;

    logic               acc, is_drain, take_pix, take_drn, take;
    logic [COORD_W-1:0] col0;
    logic [CFG_W-1:0]   col_nx, row_nx;
    logic               last_col, last_row;
    logic [CFG_W-1:0]   sat_w, sat_h;

    line_req_t             req;
    logic [PIXEL_BITS-1:0] prev_q0, prev_q1, old_q;
    logic [PIXEL_BITS-1:0] e_px, f_px, d_px, b_px, h_px, b_raw;
    blk_t                  blk;
    result_t               res, fifo_out;
    logic                  push;
    logic [FIFO_AW:0]      level;

    // ---------------- stage 0: accept, address, sequence ----------------
    assign acc      = s_tvalid & s_tready;
    assign is_drain = (s_tuser[0] == MODE_DRAIN);
    assign take_pix = acc & ~is_drain & ~awaiting_reg;
    assign take_drn = acc & is_drain & awaiting_reg;
    assign take     = take_pix | take_drn;
    assign col0     = take_drn ? drain_col_reg : in_col_reg;
    assign col_nx   = {1'b0, col0} + 1'b1;
    assign row_nx   = {1'b0, in_row_reg} + 1'b1;
    assign last_col = (col_nx >= w_reg);
    assign last_row = (row_nx >= h_reg);

    assign sat_w = (cfg_wdata == '0) ? CFG_W'(1) : (cfg_wdata > DEPTH_V) ? DEPTH_V : cfg_wdata;
    assign sat_h = (cfg_wdata == '0) ? CFG_W'(1) : (cfg_wdata > CAP_V) ? CAP_V : cfg_wdata;

    always_comb begin
        s1_next.emit      = take_drn | (in_row_reg != '0);
        s1_next.drain     = take_drn;
        s1_next.use_b     = take_drn ? (h_reg > CFG_W'(1)) : (in_row_reg > COORD_W'(1));
        s1_next.first_col = (col0 == '0);
        s1_next.last_col  = last_col;
        s1_next.done      = take_drn & last_col;
        s1_next.row       = take_drn ? COORD_W'(h_reg - 1'b1) : in_row_reg - 1'b1;
        s1_next.col       = col0;
    end

    always_comb begin
        w_next         = w_reg;
        h_next         = h_reg;
        in_row_next    = in_row_reg;
        in_col_next    = in_col_reg;
        drain_col_next = drain_col_reg;
        awaiting_next  = awaiting_reg;
        if (take_pix) begin
            if (last_col) begin
                in_col_next = '0;
                if (last_row) begin
                    in_row_next    = '0;
                    drain_col_next = '0;
                    awaiting_next  = 1'b1;
                end else begin
                    in_row_next = in_row_reg + 1'b1;
                end
            end else begin
                in_col_next = col_nx[COORD_W-1:0];
            end
        end
        if (take_drn) begin
            if (last_col) begin
                drain_col_next = '0;
                awaiting_next  = 1'b0;
            end else begin
                drain_col_next = col_nx[COORD_W-1:0];
            end
        end
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_FRAME_WIDTH:  w_next = sat_w;
                CFG_FRAME_HEIGHT: h_next = sat_h;
                default: ;
            endcase
            in_row_next    = '0;
            in_col_next    = '0;
            drain_col_next = '0;
            awaiting_next  = 1'b0;
        end
    end

    // the row-two-up write lands in the cycle after its read; forward it when the next
    // transaction reads the same column (single-column frames)
    assign fwd_next = take & s1_valid_reg & ~s1_reg.drain & (s1_reg.col == col0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg         <= WIDTH_RST;
            h_reg         <= HEIGHT_RST;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            drain_col_reg <= '0;
            awaiting_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
        end else begin
            w_reg         <= w_next;
            h_reg         <= h_next;
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            drain_col_reg <= drain_col_next;
            awaiting_reg  <= awaiting_next;
            s1_valid_reg  <= take;
            fwd_reg       <= fwd_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg       <= s1_next;
        s1_pix_reg   <= s_tdata[PIXEL_BITS-1:0];
        fwd_data_reg <= prev_q0;
        if (s1_valid_reg) begin
            last_e_reg <= prev_q0;
        end
    end

    // ---------------- line stores ----------------
    always_comb begin
        req.rd_en    = take;
        req.rd_col   = col0;
        req.prev_we  = take_pix;
        req.prev_col = col0;
        req.old_we   = s1_valid_reg & ~s1_reg.drain;
        req.old_col  = s1_reg.col;
    end

    s2x_line_mem #(
        .DEPTH      (DEPTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_mem (
        .aclk       (aclk),
        .req        (req),
        .prev_wdata (s_tdata[PIXEL_BITS-1:0]),
        .old_wdata  (prev_q0),
        .prev_q0    (prev_q0),
        .prev_q1    (prev_q1),
        .old_q      (old_q)
    );

    // ---------------- stage 1: neighbors and blend ----------------
    always_comb begin
        e_px  = prev_q0;
        f_px  = s1_reg.last_col ? e_px : prev_q1;
        d_px  = s1_reg.first_col ? e_px : last_e_reg;
        b_raw = fwd_reg ? fwd_data_reg : old_q;
        b_px  = s1_reg.use_b ? b_raw : e_px;
        h_px  = s1_reg.drain ? e_px : s1_pix_reg;
        blk   = s2x_blend(PIX_W'(b_px), PIX_W'(d_px), PIX_W'(e_px), PIX_W'(f_px), PIX_W'(h_px));
        res.blk  = blk;
        res.row  = s1_reg.row;
        res.col  = s1_reg.col;
        res.done = s1_reg.done;
    end

    assign push = s1_valid_reg & s1_reg.emit;

    s2x_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .din       (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .dout      (fifo_out),
        .level     (level)
    );

    // hold back input while the FIFO plus the item in flight could fill it
    assign s_tready = (((FIFO_AW+2)'(level) + (FIFO_AW+2)'(s1_valid_reg)) < FILL_LIMIT);

    assign m_tdata = {fifo_out.col, fifo_out.row, fifo_out.blk.br, fifo_out.blk.bl,
                      fifo_out.blk.tr, fifo_out.blk.tl};
    assign m_tlast = fifo_out.done;

    // ---------------- checks ----------------
    a_fifo_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (level < (FIFO_AW+1)'(FIFO_DEPTH)))
        else $error("output FIFO overrun");

    a_fwd_single_col: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_next |-> (w_reg == CFG_W'(1)))
        else $error("line store forward on a frame wider than one column");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, in_col_reg} < w_reg) && ({1'b0, drain_col_reg} < w_reg))
        else $error("column counter beyond frame width");

    a_drain_parked: assert property (@(posedge aclk) disable iff (!aresetn)
        awaiting_reg |-> (in_col_reg == '0) && (in_row_reg == '0))
        else $error("pixel position not parked while draining");

    a_done_on_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_reg.done) |-> s1_reg.drain && s1_reg.last_col)
        else $error("frame end flagged outside the last drain block");

endmodule

// ----- sv/s2x_line_mem.sv -----
module s2x_line_mem #(
    parameter int DEPTH      = s2x_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = s2x_pkg::DEF_PIXEL_BITS
) (
    input  logic                  aclk,
    input  s2x_pkg::line_req_t    req,
    input  logic [PIXEL_BITS-1:0] prev_wdata,
    input  logic [PIXEL_BITS-1:0] old_wdata,
    output logic [PIXEL_BITS-1:0] prev_q0,
    output logic [PIXEL_BITS-1:0] prev_q1,
    output logic [PIXEL_BITS-1:0] old_q
);
    import s2x_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [PIXEL_BITS-1:0] prev_mem [DEPTH];
    logic [PIXEL_BITS-1:0] old_mem  [DEPTH];
    logic [COORD_W-1:0]    rd_col_nx;

    assign rd_col_nx = req.rd_col + 1'b1;

    // read-before-write: the centre read sees the row above, not this pixel
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            prev_q0 <= prev_mem[req.rd_col[AW-1:0]];
            prev_q1 <= prev_mem[rd_col_nx[AW-1:0]];
        end
        if (req.prev_we) begin
            prev_mem[req.prev_col[AW-1:0]] <= prev_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            old_q <= old_mem[req.rd_col[AW-1:0]];
        end
        if (req.old_we) begin
            old_mem[req.old_col[AW-1:0]] <= old_wdata;
        end
    end

endmodule

// ----- sv/s2x_out_fifo.sv -----
module s2x_out_fifo (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  s2x_pkg::result_t             din,
    output logic                         out_valid,
    input  logic                         out_ready,
    output s2x_pkg::result_t             dout,
    output logic [s2x_pkg::FIFO_AW:0]    level
);
    import s2x_pkg::*;

    result_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     cnt_reg, cnt_next;
    logic                 pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid & out_ready;
    assign dout      = mem[rd_ptr_reg];
    assign level     = cnt_reg;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule
